FILE: hw/rtl/sbpm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the sparse poly multiplier.
`default_nettype none
package sbpm_pkg;

  localparam int FIRST_DEPTH  = 8;
  localparam int SECOND_DEPTH = 8;
  localparam int EXP_BITS     = 8;
  localparam int PROD_DEPTH   = 64;

  localparam int ACNT_W = $clog2(FIRST_DEPTH + 1);
  localparam int BCNT_W = $clog2(SECOND_DEPTH + 1);
  localparam int AIDX_W = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
  localparam int BIDX_W = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
  localparam int PCNT_W = $clog2(PROD_DEPTH + 1);
  localparam int PIDX_W = $clog2(PROD_DEPTH);

  localparam int OP_W       = 2;
  localparam int COEF_W     = 16;
  localparam int EXP_IN_W   = 8;
  localparam int STATUS_W   = 3;
  localparam int PCOEF_W    = 40;
  localparam int EXP_OUT_W  = 9;
  localparam int PEXP_W     = EXP_BITS + 1;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL    = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MERGED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PROD    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

  typedef struct packed {
    logic signed [PCOEF_W-1:0] coef;
    logic [PEXP_W-1:0]         ex;
    logic [PEXP_W-1:0]         ey;
  } prod_entry_t;

  typedef struct packed {
    logic capture;
    logic do_load;
    logic do_clear;
    logic mul_init;
    logic form_prod;
    logic srch_rd;
    logic k_inc;
    logic upd;
    logic append;
    logic shift_rd;
    logic shift_wr;
    logic dec_pc;
    logic pair_next;
    logic emit_init;
    logic emit_rd;
    logic emit_out;
    logic emit_empty;
  } sbpm_cmd_t;

  typedef struct packed {
    logic pairs_done;
    logic k_at_end;
    logic match;
    logic sum_zero;
    logic shift_done;
    logic pc_zero;
    logic out_free;
  } sbpm_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sbpm_datapath.sv
// Datapath: term tables, product memory, multiplier, merge arithmetic and output register.
`default_nettype none
module sbpm_datapath
  import sbpm_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [OP_W-1:0]             op_i,
  input  wire logic signed [COEF_W-1:0]    coef_in_i,
  input  wire logic [EXP_IN_W-1:0]         exp_x_in_i,
  input  wire logic [EXP_IN_W-1:0]         exp_y_in_i,
  input  wire sbpm_cmd_t                   cmd_i,
  output sbpm_stat_t                       stat_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [STATUS_W-1:0]              status_o,
  output logic signed [PCOEF_W-1:0]        coef_out_o,
  output logic [EXP_OUT_W-1:0]             exp_x_out_o,
  output logic [EXP_OUT_W-1:0]             exp_y_out_o,
  output logic                             last_o
);

  // latched input word
  logic [OP_W-1:0]          op_q;
  logic signed [COEF_W-1:0] lc_q;
  logic [EXP_BITS-1:0]      lx_q, ly_q;

  logic signed [COEF_W-1:0] a_coef_q [FIRST_DEPTH];
  logic [EXP_BITS-1:0]      a_ex_q   [FIRST_DEPTH];
  logic [EXP_BITS-1:0]      a_ey_q   [FIRST_DEPTH];
  logic signed [COEF_W-1:0] b_coef_q [SECOND_DEPTH];
  logic [EXP_BITS-1:0]      b_ex_q   [SECOND_DEPTH];
  logic [EXP_BITS-1:0]      b_ey_q   [SECOND_DEPTH];
  logic [ACNT_W-1:0]        cnt_a_q;
  logic [BCNT_W-1:0]        cnt_b_q;

  logic [ACNT_W-1:0] i_q;
  logic [BCNT_W-1:0] j_q;
  logic [PCNT_W-1:0] k_q, pc_q;

  prod_entry_t mem [PROD_DEPTH];
  prod_entry_t rdata_q;
  prod_entry_t prod_q;

  logic                      out_valid_q;
  logic [STATUS_W-1:0]       status_q;
  logic signed [PCOEF_W-1:0] coef_q;
  logic [EXP_OUT_W-1:0]      ex_out_q, ey_out_q;
  logic                      last_q;

  // load search over A and B
  logic              a_hit, b_hit;
  logic [AIDX_W-1:0] a_idx;
  logic [BIDX_W-1:0] b_idx;
  logic [COEF_W:0]   a_sum, b_sum;
  logic signed [COEF_W-1:0] a_sat, b_sat;
  logic              a_full, b_full;
  logic              ld_hit, ld_zero, ld_full;
  logic [STATUS_W-1:0] ld_status;

  always_comb begin
    a_hit = 1'b0;
    a_idx = '0;
    for (int m = FIRST_DEPTH - 1; m >= 0; m--) begin
      if (m < int'(cnt_a_q) && a_ex_q[m] == lx_q && a_ey_q[m] == ly_q) begin
        a_hit = 1'b1;
        a_idx = AIDX_W'(m);
      end
    end
    b_hit = 1'b0;
    b_idx = '0;
    for (int m = SECOND_DEPTH - 1; m >= 0; m--) begin
      if (m < int'(cnt_b_q) && b_ex_q[m] == lx_q && b_ey_q[m] == ly_q) begin
        b_hit = 1'b1;
        b_idx = BIDX_W'(m);
      end
    end
  end

  always_comb begin
    a_sum = {a_coef_q[a_idx][COEF_W-1], a_coef_q[a_idx]} + {lc_q[COEF_W-1], lc_q};
    b_sum = {b_coef_q[b_idx][COEF_W-1], b_coef_q[b_idx]} + {lc_q[COEF_W-1], lc_q};
    // saturate to Q8.8
    if (a_sum[COEF_W] != a_sum[COEF_W-1]) begin
      a_sat = a_sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      a_sat = a_sum[COEF_W-1:0];
    end
    if (b_sum[COEF_W] != b_sum[COEF_W-1]) begin
      b_sat = b_sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      b_sat = b_sum[COEF_W-1:0];
    end
    a_full = (int'(cnt_a_q) >= FIRST_DEPTH);
    b_full = (int'(cnt_b_q) >= SECOND_DEPTH);
    if (op_q == OP_LOAD_A) begin
      ld_hit  = a_hit;
      ld_zero = (a_sat == '0);
      ld_full = a_full;
    end else begin
      ld_hit  = b_hit;
      ld_zero = (b_sat == '0);
      ld_full = b_full;
    end
    if (ld_hit) begin
      ld_status = ld_zero ? ST_REMOVED : ST_MERGED;
    end else begin
      ld_status = ld_full ? ST_FULL : ST_NEW;
    end
  end

  // product merge arithmetic
  logic [PCOEF_W:0]          p_sum;
  logic signed [PCOEF_W-1:0] p_sat;
  prod_entry_t               wdata;
  logic [PIDX_W-1:0]         waddr, raddr;
  logic                      wen, ren;

  always_comb begin
    p_sum = {rdata_q.coef[PCOEF_W-1], rdata_q.coef} + {prod_q.coef[PCOEF_W-1], prod_q.coef};
    if (p_sum[PCOEF_W] != p_sum[PCOEF_W-1]) begin
      p_sat = p_sum[PCOEF_W] ? {1'b1, {(PCOEF_W-1){1'b0}}} : {1'b0, {(PCOEF_W-1){1'b1}}};
    end else begin
      p_sat = p_sum[PCOEF_W-1:0];
    end
    wen   = cmd_i.upd || cmd_i.shift_wr || (cmd_i.append && int'(pc_q) < PROD_DEPTH);
    waddr = cmd_i.append ? pc_q[PIDX_W-1:0] : k_q[PIDX_W-1:0];
    if (cmd_i.append) begin
      wdata = prod_q;
    end else if (cmd_i.upd) begin
      wdata = '{coef: p_sat, ex: rdata_q.ex, ey: rdata_q.ey};
    end else begin
      wdata = rdata_q;
    end
    ren   = cmd_i.srch_rd || cmd_i.shift_rd || cmd_i.emit_rd;
    raddr = cmd_i.shift_rd ? PIDX_W'(k_q + 1'b1) : k_q[PIDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    stat_o.pairs_done = (i_q >= cnt_a_q) || (cnt_b_q == '0);
    stat_o.k_at_end   = (k_q == pc_q);
    stat_o.match      = (rdata_q.ex == prod_q.ex) && (rdata_q.ey == prod_q.ey);
    stat_o.sum_zero   = (p_sat == '0);
    stat_o.shift_done = ({1'b0, k_q} + 1'b1 >= {1'b0, pc_q});
    stat_o.pc_zero    = (pc_q == '0);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= op_i;
      lc_q <= coef_in_i;
      lx_q <= EXP_BITS'(exp_x_in_i);
      ly_q <= EXP_BITS'(exp_y_in_i);
    end
    if (cmd_i.form_prod) begin
      prod_q.coef <= PCOEF_W'(a_coef_q[i_q[AIDX_W-1:0]] * b_coef_q[j_q[BIDX_W-1:0]]);
      prod_q.ex   <= PEXP_W'(a_ex_q[i_q[AIDX_W-1:0]]) + PEXP_W'(b_ex_q[j_q[BIDX_W-1:0]]);
      prod_q.ey   <= PEXP_W'(a_ey_q[i_q[AIDX_W-1:0]]) + PEXP_W'(b_ey_q[j_q[BIDX_W-1:0]]);
    end
    if (cmd_i.do_load && op_q == OP_LOAD_A) begin
      if (a_hit) begin
        if (a_sat != '0) begin
          a_coef_q[a_idx] <= a_sat;
        end else begin
          // shift later entries down
          for (int m = 0; m < FIRST_DEPTH - 1; m++) begin
            if (m >= int'(a_idx) && m + 1 < int'(cnt_a_q)) begin
              a_coef_q[m] <= a_coef_q[m+1];
              a_ex_q[m]   <= a_ex_q[m+1];
              a_ey_q[m]   <= a_ey_q[m+1];
            end
          end
        end
      end else if (!a_full) begin
        a_coef_q[cnt_a_q[AIDX_W-1:0]] <= lc_q;
        a_ex_q[cnt_a_q[AIDX_W-1:0]]   <= lx_q;
        a_ey_q[cnt_a_q[AIDX_W-1:0]]   <= ly_q;
      end
    end
    if (cmd_i.do_load && op_q == OP_LOAD_B) begin
      if (b_hit) begin
        if (b_sat != '0) begin
          b_coef_q[b_idx] <= b_sat;
        end else begin
          for (int m = 0; m < SECOND_DEPTH - 1; m++) begin
            if (m >= int'(b_idx) && m + 1 < int'(cnt_b_q)) begin
              b_coef_q[m] <= b_coef_q[m+1];
              b_ex_q[m]   <= b_ex_q[m+1];
              b_ey_q[m]   <= b_ey_q[m+1];
            end
          end
        end
      end else if (!b_full) begin
        b_coef_q[cnt_b_q[BIDX_W-1:0]] <= lc_q;
        b_ex_q[cnt_b_q[BIDX_W-1:0]]   <= lx_q;
        b_ey_q[cnt_b_q[BIDX_W-1:0]]   <= ly_q;
      end
    end
    if (cmd_i.do_load) begin
      status_q <= ld_status;
      coef_q   <= '0;
      ex_out_q <= EXP_OUT_W'(lx_q);
      ey_out_q <= EXP_OUT_W'(ly_q);
      last_q   <= 1'b1;
    end else if (cmd_i.emit_out) begin
      status_q <= ST_PROD;
      coef_q   <= rdata_q.coef;
      ex_out_q <= EXP_OUT_W'(rdata_q.ex);
      ey_out_q <= EXP_OUT_W'(rdata_q.ey);
      last_q   <= ({1'b0, k_q} + 1'b1 == {1'b0, pc_q});
    end else if (cmd_i.emit_empty) begin
      status_q <= ST_EMPTY;
      coef_q   <= '0;
      ex_out_q <= '0;
      ey_out_q <= '0;
      last_q   <= 1'b1;
    end
  end

  // counts, indices and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      pc_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.do_clear) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
        pc_q    <= '0;
      end
      if (cmd_i.do_load && op_q == OP_LOAD_A) begin
        if (a_hit && a_sat == '0) begin
          cnt_a_q <= cnt_a_q - 1'b1;
        end else if (!a_hit && !a_full) begin
          cnt_a_q <= cnt_a_q + 1'b1;
        end
      end
      if (cmd_i.do_load && op_q == OP_LOAD_B) begin
        if (b_hit && b_sat == '0) begin
          cnt_b_q <= cnt_b_q - 1'b1;
        end else if (!b_hit && !b_full) begin
          cnt_b_q <= cnt_b_q + 1'b1;
        end
      end
      if (cmd_i.mul_init) begin
        i_q  <= '0;
        j_q  <= '0;
        pc_q <= '0;
      end
      if (cmd_i.form_prod || cmd_i.emit_init) begin
        k_q <= '0;
      end
      if (cmd_i.k_inc || cmd_i.shift_wr || cmd_i.emit_out) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.append && int'(pc_q) < PROD_DEPTH) begin
        pc_q <= pc_q + 1'b1;
      end
      if (cmd_i.dec_pc) begin
        pc_q <= pc_q - 1'b1;
      end
      if (cmd_i.pair_next) begin
        if ({1'b0, j_q} + 1'b1 >= {1'b0, cnt_b_q}) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      if (cmd_i.do_load || cmd_i.emit_out || cmd_i.emit_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign coef_out_o  = coef_q;
  assign exp_x_out_o = ex_out_q;
  assign exp_y_out_o = ey_out_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

FILE: hw/rtl/sbpm_ctrl.sv
// Controller state machine: sequences loads, the pairwise product merge and the emit pass.
`default_nettype none
module sbpm_ctrl
  import sbpm_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [OP_W-1:0] op_i,
  input  wire sbpm_stat_t      stat_i,
  output sbpm_cmd_t            cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_PAIR,
    S_SRD,
    S_SCMP,
    S_SHRD,
    S_SHWR,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   eout_q, eout_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    eout_d  = eout_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          unique case (op_i)
            OP_LOAD_A, OP_LOAD_B: state_d = S_LOAD;
            OP_MUL: begin
              cmd_o.mul_init = 1'b1;
              state_d = S_PAIR;
            end
            OP_CLEAR: cmd_o.do_clear = 1'b1;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.do_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PAIR: begin
        if (stat_i.pairs_done) begin
          cmd_o.emit_init = 1'b1;
          eout_d  = 1'b0;
          state_d = S_EMIT;
        end else begin
          cmd_o.form_prod = 1'b1;
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        if (stat_i.k_at_end) begin
          cmd_o.append    = 1'b1;
          cmd_o.pair_next = 1'b1;
          state_d = S_PAIR;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (!stat_i.match) begin
          cmd_o.k_inc = 1'b1;
          state_d = S_SRD;
        end else if (!stat_i.sum_zero) begin
          cmd_o.upd       = 1'b1;
          cmd_o.pair_next = 1'b1;
          state_d = S_PAIR;
        end else begin
          state_d = S_SHRD;
        end
      end
      S_SHRD: begin
        if (stat_i.shift_done) begin
          cmd_o.dec_pc    = 1'b1;
          cmd_o.pair_next = 1'b1;
          state_d = S_PAIR;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        state_d = S_SHRD;
      end
      S_EMIT: begin
        if (stat_i.pc_zero) begin
          if (stat_i.out_free) begin
            cmd_o.emit_empty = 1'b1;
            state_d = S_IDLE;
          end
        end else if (!eout_q) begin
          if (stat_i.k_at_end) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.emit_rd = 1'b1;
            eout_d = 1'b1;
          end
        end else if (stat_i.out_free) begin
          // hold the read word until the output register frees up
          cmd_o.emit_out = 1'b1;
          eout_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      eout_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      eout_q  <= eout_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sparse_bivariate_poly_multiply_top.sv
// Sparse bivariate polynomial multiplier: top level joining controller and datapath.
//
// Input channel (in_valid_i/in_ready_o) takes one word: op, Q8.8 coefficient, x and y
// exponents. Output channel (out_valid_o/out_ready_i) returns result words.
// A load into A or B gives one word once the output register is free (status new, merged,
// removed or dropped at full table). Clear gives no word and takes effect as it is accepted.
// Multiply walks every pair A[i]*B[j]: it forms the product, searches the product table
// entry by entry for equal exponents, then appends it at the end if none matches, adds
// it in place when the merged sum is nonzero, or moves the later entries down when the
// merged sum hits zero. It then emits each product term, last set on the final one, or
// a single empty-product word when the table is empty.
// One word is in flight at a time; a new input is taken once the previous item's
// words are all in the output register or delivered.
// Reset empties A, B and the product table; the output register is left invalid.
// When the receiver stalls, the output word holds and the work stops until it frees.
`default_nettype none
module sparse_bivariate_poly_multiply_top
  import sbpm_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [OP_W-1:0]          op_i,
  input  wire logic signed [COEF_W-1:0] coef_in_i,
  input  wire logic [EXP_IN_W-1:0]      exp_x_in_i,
  input  wire logic [EXP_IN_W-1:0]      exp_y_in_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [STATUS_W-1:0]           status_o,
  output logic signed [PCOEF_W-1:0]     coef_out_o,
  output logic [EXP_OUT_W-1:0]          exp_x_out_o,
  output logic [EXP_OUT_W-1:0]          exp_y_out_o,
  output logic                          last_o
);

  sbpm_cmd_t  cmd;
  sbpm_stat_t stat;

  sbpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sbpm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op_i),
    .coef_in_i   (coef_in_i),
    .exp_x_in_i  (exp_x_in_i),
    .exp_y_in_i  (exp_y_in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .coef_out_o  (coef_out_o),
    .exp_x_out_o (exp_x_out_o),
    .exp_y_out_o (exp_y_out_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire
